/* design/tdgc_pkg.sv */
// ----------------------------------------------------------------------------
// tdgc_pkg
// shared types and constants of the track/detection gating cost pipeline
// ----------------------------------------------------------------------------
package tdgc_pkg;

    localparam int POS_W   = 32;               // signed q24.8 position
    localparam int MAG_W   = 32;               // magnitude of a difference
    localparam int SIG_W   = 24;               // q16.8 sigma
    localparam int SQ_W    = 2 * MAG_W;        // squared difference
    localparam int S2_W    = 2 * SIG_W;        // squared sigma
    localparam int ACC_W   = SQ_W + 2;         // sum of three squares
    localparam int LIM_W   = 62;               // max_distance squared
    localparam int QUO_W   = 40;               // quotient bits below the cap
    localparam int REM_W   = S2_W + QUO_W;     // dividend / remainder
    localparam int TERM_W  = QUO_W + 1;        // capped term, up to 2^40
    localparam int SUM_W   = TERM_W + 2;       // sum of three terms
    localparam int ROOT_W  = 31;               // euclidean root bits
    localparam int COST_W  = 32;
    localparam int MAXD_W  = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NSTG    = QUO_W;            // bit stages of divide / root

    localparam logic [SIG_W-1:0] SIG_XY_DEF = 24'd2560;   // 10 m
    localparam logic [SIG_W-1:0] SIG_Z_DEF  = 24'd5120;   // 20 m
    localparam logic [TERM_W-1:0] TERM_CAP  = {1'b1, {QUO_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_STATISTICAL = 2'd2;

    localparam logic [31:0] GATE_RST = 32'd589824;
    localparam logic [MAXD_W-1:0] MAXD_RST = 31'd256000;

    // after the difference stage
    typedef struct packed {
        logic                       v;
        logic                       act;
        logic [2:0][MAG_W-1:0]      mag;
        logic [2:0][SIG_W-1:0]      sig;
    } t_sa;

    // after the square stage
    typedef struct packed {
        logic                       v;
        logic                       act;
        logic [2:0][SQ_W-1:0]       d2;
        logic [2:0][S2_W-1:0]       s2;
    } t_sb;

    // one stage of the divide / square root chain
    typedef struct packed {
        logic                       v;
        logic                       act;
        logic                       dist_ok;
        logic [2:0]                 cap;
        logic [2:0][REM_W-1:0]      rem;
        logic [2:0][S2_W-1:0]       den;
        logic [2:0][QUO_W-1:0]      quo;
        logic [LIM_W-1:0]           srem;
        logic [ROOT_W-1:0]          root;
    } t_pipe;

endpackage

/* design/tdgc_if.sv */
// ----------------------------------------------------------------------------
// tdgc interfaces
// valid/ready channels for the pair input and the cost output
// ----------------------------------------------------------------------------
interface tdgc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;
    logic signed [31:0] track_z;
    logic               track_z_valid;
    logic [23:0]        sigma_x;
    logic [23:0]        sigma_y;
    logic [23:0]        sigma_z;
    logic               track_active;
    logic signed [31:0] det_x;
    logic signed [31:0] det_y;
    logic signed [31:0] det_z;
    logic               det_z_valid;

    modport source (
        output valid, track_x, track_y, track_z, track_z_valid, sigma_x, sigma_y,
               sigma_z, track_active, det_x, det_y, det_z, det_z_valid,
        input  ready
    );
    modport sink (
        input  valid, track_x, track_y, track_z, track_z_valid, sigma_x, sigma_y,
               sigma_z, track_active, det_x, det_y, det_z, det_z_valid,
        output ready
    );
endinterface

interface tdgc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cost;
    logic        cost_valid;

    modport source (output valid, cost, cost_valid, input ready);
    modport sink   (input valid, cost, cost_valid, output ready);
endinterface

/* design/track_detection_gating_cost_top.sv */
// ----------------------------------------------------------------------------
// track_detection_gating_cost_top
// gated association cost (euclidean or sigma-normalized) for one
// track/detection pair per transaction, fully pipelined
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_pair    in   valid/ready   track/detection positions, sigmas, flags
//  o_cost    out  valid/ready   cost, cost_valid
//  i_cfg_*   in   write enable  gate_threshold, max_distance, use_statistical
//
//  one pair per cycle while i_pair.ready is high; registers in order: difference,
//  square, sum/gate setup, 40 one-bit divide and root stages, output register
//  the 40-stage restoring divide (three lanes) and the 31-bit root set depth
//  reset clears valid bits and loads the register defaults
//  a stall freezes the whole pipe only when the output skid entry is full;
//  i_pair.ready is registered-state driven, nothing is lost or repeated
// ----------------------------------------------------------------------------
module track_detection_gating_cost_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tdgc_in_if.sink                            i_pair,
    tdgc_out_if.source                         o_cost,
    input  logic                               i_cfg_we,
    input  logic [tdgc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tdgc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tdgc_pkg::*;

    // configuration registers
    logic [31:0]        r_gate_thr;
    logic [MAXD_W-1:0]  r_max_dist;
    logic               r_use_stat;
    logic [LIM_W-1:0]   r_lim;          // max_distance squared

    // pipeline
    logic               w_en;
    t_sa                r_a, n_a;
    t_sb                r_b, n_b;
    t_pipe              r_pipe [0:NSTG];
    t_pipe              n_pipe [0:NSTG];

    // output register and skid entry
    logic               r_o_v, r_s_v;
    logic [COST_W-1:0]  r_o_cost, r_s_cost;
    logic               r_o_cv, r_s_cv;
    logic [COST_W-1:0]  w_cost;
    logic               w_cv;

    // differences and sigma magnitudes
    logic signed [POS_W:0] w_dx, w_dy, w_dz;
    logic                  w_zok;

    // pipe advances unless the skid entry is holding a result
    assign w_en        = !r_s_v;
    assign i_pair.ready = w_en;

    // config writes, and the squared distance limit, registered from r_max_dist
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_thr <= GATE_RST;
            r_max_dist <= MAXD_RST;
            r_use_stat <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GATE_THRESHOLD:  r_gate_thr <= i_cfg_data;
                CFG_MAX_DISTANCE:    r_max_dist <= i_cfg_data[MAXD_W-1:0];
                CFG_USE_STATISTICAL: r_use_stat <= i_cfg_data[0];
                default: ;
            endcase
        end
        r_lim <= LIM_W'(r_max_dist) * LIM_W'(r_max_dist);
    end

    // stage a: signed differences to magnitudes (z zeroed unless both z valid), default sigmas
    assign w_dx  = (POS_W+1)'(i_pair.track_x) - (POS_W+1)'(i_pair.det_x);
    assign w_dy  = (POS_W+1)'(i_pair.track_y) - (POS_W+1)'(i_pair.det_y);
    assign w_dz  = (POS_W+1)'(i_pair.track_z) - (POS_W+1)'(i_pair.det_z);
    assign w_zok = i_pair.track_z_valid & i_pair.det_z_valid;

    always_comb begin
        n_a.v      = i_pair.valid;
        n_a.act    = i_pair.track_active;
        n_a.mag[0] = w_dx[POS_W] ? MAG_W'(-w_dx) : w_dx[MAG_W-1:0];
        n_a.mag[1] = w_dy[POS_W] ? MAG_W'(-w_dy) : w_dy[MAG_W-1:0];
        n_a.mag[2] = !w_zok ? '0 : (w_dz[POS_W] ? MAG_W'(-w_dz) : w_dz[MAG_W-1:0]);
        n_a.sig[0] = (i_pair.sigma_x == '0) ? SIG_XY_DEF : i_pair.sigma_x;
        n_a.sig[1] = (i_pair.sigma_y == '0) ? SIG_XY_DEF : i_pair.sigma_y;
        n_a.sig[2] = (i_pair.sigma_z == '0) ? SIG_Z_DEF  : i_pair.sigma_z;
    end

    // stage b: squares
    always_comb begin
        n_b.v   = r_a.v;
        n_b.act = r_a.act;
        for (int a = 0; a < 3; a++) begin
            n_b.d2[a] = SQ_W'(r_a.mag[a]) * SQ_W'(r_a.mag[a]);
            n_b.s2[a] = S2_W'(r_a.sig[a]) * S2_W'(r_a.sig[a]);
        end
    end

    // stage c: distance sum and gate, term cap, divider and root setup
    always_comb begin
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(r_b.d2[0]) + ACC_W'(r_b.d2[1]) + ACC_W'(r_b.d2[2]);
        n_pipe[0].v       = r_b.v;
        n_pipe[0].act     = r_b.act;
        n_pipe[0].dist_ok = (acc <= ACC_W'(r_lim));
        n_pipe[0].srem    = acc[LIM_W-1:0];
        n_pipe[0].root    = '0;
        for (int a = 0; a < 3; a++) begin
            // term reaches 2^40 when d2 >= s2 * 2^24
            n_pipe[0].cap[a] = ((SQ_W+8)'(r_b.d2[a]) >= ((SQ_W+8)'(r_b.s2[a]) << 24));
            n_pipe[0].rem[a] = REM_W'(r_b.d2[a]) << 16;
            n_pipe[0].den[a] = r_b.s2[a];
            n_pipe[0].quo[a] = '0;
        end
    end

    // one quotient bit per lane per stage; one root bit per stage once the bit index is below ROOT_W
    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        localparam int Bi = NSTG - 1 - k;
        always_comb begin
            logic [REM_W-1:0] dsh;
            n_pipe[k+1] = r_pipe[k];
            for (int a = 0; a < 3; a++) begin
                dsh = REM_W'(r_pipe[k].den[a]) << Bi;
                if (r_pipe[k].rem[a] >= dsh) begin
                    n_pipe[k+1].rem[a]     = r_pipe[k].rem[a] - dsh;
                    n_pipe[k+1].quo[a][Bi] = 1'b1;
                end
            end
            if (Bi < ROOT_W) begin
                if (r_pipe[k].srem >= ((LIM_W'(r_pipe[k].root) << (Bi + 1))
                                       | (LIM_W'(1) << (2 * Bi)))) begin
                    n_pipe[k+1].srem = r_pipe[k].srem
                                     - ((LIM_W'(r_pipe[k].root) << (Bi + 1))
                                        | (LIM_W'(1) << (2 * Bi)));
                    n_pipe[k+1].root[Bi % ROOT_W] = 1'b1;
                end
            end
        end
    end

    // pipe registers; valid bits reset, payload does not need it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.v <= 1'b0;
            r_b.v <= 1'b0;
            for (int k = 0; k <= NSTG; k++) r_pipe[k].v <= 1'b0;
        end else if (w_en) begin
            r_a <= n_a;
            r_b <= n_b;
            for (int k = 0; k <= NSTG; k++) r_pipe[k] <= n_pipe[k];
        end
    end

    // final gating: sum of capped terms, distance gate, chi-square gate in statistical mode, cost select
    always_comb begin
        logic [TERM_W-1:0] term [3];
        logic [SUM_W-1:0]  ssum;
        logic              pass;
        for (int a = 0; a < 3; a++)
            term[a] = r_pipe[NSTG].cap[a] ? TERM_CAP : {1'b0, r_pipe[NSTG].quo[a]};
        ssum = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
        if (r_use_stat)
            pass = r_pipe[NSTG].dist_ok && (ssum <= SUM_W'(r_gate_thr));
        else
            pass = r_pipe[NSTG].dist_ok;
        w_cv = r_pipe[NSTG].act && pass;
        if (!w_cv)
            w_cost = '0;
        else if (r_use_stat)
            w_cost = (ssum[SUM_W-1:COST_W] != '0) ? '1 : ssum[COST_W-1:0];
        else
            w_cost = COST_W'(r_pipe[NSTG].root);
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (o_cost.ready) begin
                r_o_v    <= 1'b1;
                r_o_cost <= r_s_cost;
                r_o_cv   <= r_s_cv;
                r_s_v    <= 1'b0;
            end
        end else if (!r_o_v || o_cost.ready) begin
            r_o_v    <= r_pipe[NSTG].v;
            r_o_cost <= w_cost;
            r_o_cv   <= w_cv;
        end else if (r_pipe[NSTG].v) begin
            r_s_v    <= 1'b1;
            r_s_cost <= w_cost;
            r_s_cv   <= w_cv;
        end
    end

    assign o_cost.valid      = r_o_v;
    assign o_cost.cost       = r_o_cost;
    assign o_cost.cost_valid = r_o_cv;

    // a gated-out result always carries zero cost
    a_zero_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o_cv) |-> (r_o_cost == '0))
        else $error("gated result with nonzero cost");

    // skid entry only fills behind a waiting output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> r_o_v)
        else $error("skid holds data while output empty");

    // a frozen pipe keeps the valid bit of its last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && $past(i_rst_n)) |=> $stable(r_pipe[NSTG].v))
        else $error("pipe moved during stall");

endmodule
